// ----- src/skn_pkg.sv -----
// skn_pkg: shared constants, types and key text for the schedule key/number parser
// no dependencies; used by skn_key_match, the top level and the checker
package skn_pkg;

  // table and key limits
  localparam int TABLE_CAPACITY  = 40;
  localparam int MAX_KEY_LETTERS = 10;
  localparam int NUM_KEYS        = 3;

  // widths derived from the limits
  localparam int CNT_W     = $clog2(TABLE_CAPACITY + 1);
  localparam int KLEN_W    = $clog2(MAX_KEY_LETTERS + 2);
  localparam int IDX_W     = 6;
  localparam int IDX_EXT_W = (CNT_W > IDX_W) ? CNT_W : IDX_W;
  localparam int NUM_W     = 32;

  // character bounds
  localparam logic [7:0] CHR_UPPER_A = 8'h41;
  localparam logic [7:0] CHR_UPPER_Z = 8'h5A;
  localparam logic [7:0] CHR_LOWER_A = 8'h61;
  localparam logic [7:0] CHR_LOWER_Z = 8'h7A;
  localparam logic [7:0] CHR_ZERO    = 8'h30;
  localparam logic [7:0] CHR_NINE    = 8'h39;

  // recognized keys
  typedef enum logic [1:0] {
    KEY_ZONE  = 2'd0,
    KEY_START = 2'd1,
    KEY_END   = 2'd2
  } key_t;

  localparam logic [8*10-1:0] ZONE_TEXT  = "zoneNumber";
  localparam logic [8*9-1:0]  START_TEXT = "startTime";
  localparam logic [8*7-1:0]  END_TEXT   = "endTime";
  localparam int ZONE_LEN  = 10;
  localparam int START_LEN = 9;
  localparam int END_LEN   = 7;

  // key collection state passed to the matcher
  typedef struct packed {
    logic [NUM_KEYS-1:0] flags;
    logic [KLEN_W-1:0]   len;
  } key_state_t;

  localparam key_state_t KEY_INIT = '{flags: '1, len: '0};

  // letter count of a key
  function automatic logic [KLEN_W-1:0] key_len(input key_t k);
    logic [KLEN_W-1:0] n;
    n = '0;
    unique case (k)
      KEY_ZONE:  n = KLEN_W'(ZONE_LEN);
      KEY_START: n = KLEN_W'(START_LEN);
      KEY_END:   n = KLEN_W'(END_LEN);
      default:   n = '0;
    endcase
    return n;
  endfunction

  // character of a key at a position, zero past its end
  function automatic logic [7:0] key_char(input key_t k, input logic [KLEN_W-1:0] pos);
    logic [7:0] c;
    int p;
    c = '0;
    p = int'(pos);
    unique case (k)
      KEY_ZONE:  if (p < ZONE_LEN)  c = ZONE_TEXT[8*(ZONE_LEN-1-p) +: 8];
      KEY_START: if (p < START_LEN) c = START_TEXT[8*(START_LEN-1-p) +: 8];
      KEY_END:   if (p < END_LEN)   c = END_TEXT[8*(END_LEN-1-p) +: 8];
      default:   c = '0;
    endcase
    return c;
  endfunction

endpackage

// ----- src/skn_key_match.sv -----
// skn_key_match: takes one letter into the running key comparison
// depends on skn_pkg for key text, lengths and the key state struct
module skn_key_match (
  input  skn_pkg::key_state_t ks_in,
  input  logic [7:0]          letter,
  output skn_pkg::key_state_t ks_out
);

  logic [skn_pkg::NUM_KEYS-1:0] flags_hit;

  // per key: still a candidate if the letter matches at this position
  always_comb begin
    for (int k = 0; k < skn_pkg::NUM_KEYS; k++) begin
      flags_hit[k] = ks_in.flags[k]
                     && (ks_in.len < skn_pkg::key_len(skn_pkg::key_t'(k)))
                     && (skn_pkg::key_char(skn_pkg::key_t'(k), ks_in.len) == letter);
    end
  end

  // length saturates one past the longest key; a long run matches nothing
  always_comb begin
    ks_out.flags = flags_hit;
    ks_out.len   = ks_in.len;
    if (ks_in.len <= skn_pkg::KLEN_W'(skn_pkg::MAX_KEY_LETTERS)) begin
      ks_out.len = ks_in.len + 1'b1;
    end
    if (ks_out.len > skn_pkg::KLEN_W'(skn_pkg::MAX_KEY_LETTERS)) begin
      ks_out.flags = '0;
    end
  end

endmodule

// ----- src/schedule_key_number_parser_unit.sv -----
// schedule_key_number_parser_unit: byte stream parser for zone/start/end schedule entries
// depends on skn_pkg and skn_key_match
//
// Usage:
//   Input channel (in_valid / in_stall): one ASCII byte per item with in_message_end
//   marking the last byte of a message. Output channel (out_valid / out_stall): one
//   schedule entry per endTime number, with zone, start, end, table slot and a
//   dropped flag once the table of TABLE_CAPACITY entries is full.
//   Flow: an item is registered in the input register at acceptance and processed from
//   there once the result register is free or draining; an entry it completes is loaded
//   into the output register as the item is processed, and is taken from there.
//   Throughput: one item per cycle unless out_stall holds a result. Key matching and
//   the decimal multiply-by-ten add are one shallow stage between the two registers.
//   Stall: while a result waits under out_stall, one more item is taken into the
//   input register; in_stall then rises until the result is taken.
//   Reset (rst_n low, synchronous): parser returns to letter search, zone, pending
//   values and entry count clear, both registers empty. No clearing pass is needed.
//   Message end: after its last byte a partial key or number and the current zone are
//   dropped; pending values and the entry count are kept.
module schedule_key_number_parser_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_data_byte,
  input  logic        in_message_end,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] out_zone_number,
  output logic [31:0] out_start_value,
  output logic [31:0] out_end_value,
  output logic [5:0]  out_entry_index,
  output logic        out_dropped
);

  typedef enum logic [1:0] {
    PH_SEEK_LETTER,
    PH_IN_KEY,
    PH_SEEK_DIGIT,
    PH_IN_NUMBER
  } phase_t;

  // input register
  logic        in_vld_r;
  logic [7:0]  byte_r;
  logic        last_r;

  // parser state
  phase_t                          phase_r, phase_nxt;
  skn_pkg::key_state_t             key_r, key_nxt;
  skn_pkg::key_t                   matched_r, matched_nxt;
  logic [skn_pkg::NUM_W-1:0]       acc_r, acc_nxt;
  logic [skn_pkg::NUM_W-1:0]       cur_zone_r, cur_zone_nxt;
  logic [skn_pkg::NUM_W-1:0]       pend_zone_r, pend_zone_nxt;
  logic [skn_pkg::NUM_W-1:0]       pend_start_r, pend_start_nxt;
  logic [skn_pkg::CNT_W-1:0]       count_r, count_nxt;

  // result register
  logic                            out_vld_r;
  logic [skn_pkg::NUM_W-1:0]       o_zone_r, o_start_r, o_end_r;
  logic [skn_pkg::IDX_W-1:0]       o_idx_r, o_idx_nxt;
  logic                            o_drop_r, o_drop_nxt;

  logic                            advance;
  logic                            produce;
  logic                            is_letter, is_digit;
  logic [3:0]                      digit;
  logic [skn_pkg::NUM_W+3:0]       acc_x10;
  logic [skn_pkg::NUM_W-1:0]       acc_step;
  logic                            full;
  logic [skn_pkg::CNT_W-1:0]       idx;
  logic [skn_pkg::IDX_EXT_W-1:0]   idx_ext;
  skn_pkg::key_state_t             km_in, km_out;

  // handshake: process stage moves when the result register is free or draining
  assign advance   = in_vld_r && (!out_vld_r || !out_stall);
  assign in_stall  = in_vld_r && !advance;
  assign out_valid = out_vld_r;
  assign out_zone_number = o_zone_r;
  assign out_start_value = o_start_r;
  assign out_end_value   = o_end_r;
  assign out_entry_index = o_idx_r;
  assign out_dropped     = o_drop_r;

  // byte classes
  assign is_letter = ((byte_r >= skn_pkg::CHR_UPPER_A) && (byte_r <= skn_pkg::CHR_UPPER_Z))
                  || ((byte_r >= skn_pkg::CHR_LOWER_A) && (byte_r <= skn_pkg::CHR_LOWER_Z));
  assign is_digit  = (byte_r >= skn_pkg::CHR_ZERO) && (byte_r <= skn_pkg::CHR_NINE);
  assign digit     = byte_r[3:0];

  // key matcher starts fresh on the first letter
  assign km_in = (phase_r == PH_SEEK_LETTER) ? skn_pkg::KEY_INIT : key_r;

  skn_key_match u_key_match (
    .ks_in  (km_in),
    .letter (byte_r),
    .ks_out (km_out)
  );

  // acc * 10 + digit, saturating at all ones
  assign acc_x10  = ({4'b0, acc_r} << 3) + ({4'b0, acc_r} << 1)
                  + (skn_pkg::NUM_W+4)'(digit);
  assign acc_step = (acc_x10[skn_pkg::NUM_W+3:skn_pkg::NUM_W] != '0)
                  ? '1 : acc_x10[skn_pkg::NUM_W-1:0];

  // table slot, held at the last slot once full
  assign full    = count_r >= skn_pkg::CNT_W'(skn_pkg::TABLE_CAPACITY);
  assign idx     = full ? skn_pkg::CNT_W'(skn_pkg::TABLE_CAPACITY - 1) : count_r;
  assign idx_ext = skn_pkg::IDX_EXT_W'(idx);

  // next state for the registered item
  always_comb begin
    phase_nxt      = phase_r;
    key_nxt        = key_r;
    matched_nxt    = matched_r;
    acc_nxt        = acc_r;
    cur_zone_nxt   = cur_zone_r;
    pend_zone_nxt  = pend_zone_r;
    pend_start_nxt = pend_start_r;
    count_nxt      = count_r;
    produce        = 1'b0;
    o_idx_nxt      = idx_ext[skn_pkg::IDX_W-1:0];
    o_drop_nxt     = full;

    unique case (phase_r)
      PH_SEEK_LETTER: begin
        if (is_letter) begin
          key_nxt   = km_out;
          phase_nxt = PH_IN_KEY;
        end
      end
      PH_IN_KEY: begin
        if (is_letter) begin
          key_nxt = km_out;
        end else begin
          phase_nxt = PH_SEEK_LETTER;
          // lengths differ, so at most one key can end here
          for (int k = 0; k < skn_pkg::NUM_KEYS; k++) begin
            if (key_r.flags[k] && (key_r.len == skn_pkg::key_len(skn_pkg::key_t'(k)))) begin
              matched_nxt = skn_pkg::key_t'(k);
              acc_nxt     = '0;
              phase_nxt   = PH_SEEK_DIGIT;
            end
          end
        end
      end
      PH_SEEK_DIGIT: begin
        if (is_digit) begin
          acc_nxt   = skn_pkg::NUM_W'(digit);
          phase_nxt = PH_IN_NUMBER;
        end
      end
      PH_IN_NUMBER: begin
        if (is_digit) begin
          acc_nxt = acc_step;
        end else begin
          phase_nxt = PH_SEEK_LETTER;
          unique case (matched_r)
            skn_pkg::KEY_ZONE: cur_zone_nxt = acc_r;
            skn_pkg::KEY_START: begin
              pend_zone_nxt  = cur_zone_r;
              pend_start_nxt = acc_r;
            end
            skn_pkg::KEY_END: begin
              produce        = 1'b1;
              pend_zone_nxt  = '0;
              pend_start_nxt = '0;
              if (!full) begin
                count_nxt = count_r + 1'b1;
              end
            end
            default: ;
          endcase
        end
      end
      default: ;
    endcase

    // message end drops the partial token and the zone
    if (last_r) begin
      phase_nxt    = PH_SEEK_LETTER;
      key_nxt      = skn_pkg::KEY_INIT;
      matched_nxt  = skn_pkg::KEY_ZONE;
      acc_nxt      = '0;
      cur_zone_nxt = '0;
    end
  end

  // state, input register and result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r     <= 1'b0;
      out_vld_r    <= 1'b0;
      phase_r      <= PH_SEEK_LETTER;
      key_r        <= skn_pkg::KEY_INIT;
      matched_r    <= skn_pkg::KEY_ZONE;
      acc_r        <= '0;
      cur_zone_r   <= '0;
      pend_zone_r  <= '0;
      pend_start_r <= '0;
      count_r      <= '0;
    end else begin
      if (in_valid && !in_stall) begin
        in_vld_r <= 1'b1;
      end else if (advance) begin
        in_vld_r <= 1'b0;
      end

      if (advance) begin
        phase_r      <= phase_nxt;
        key_r        <= key_nxt;
        matched_r    <= matched_nxt;
        acc_r        <= acc_nxt;
        cur_zone_r   <= cur_zone_nxt;
        pend_zone_r  <= pend_zone_nxt;
        pend_start_r <= pend_start_nxt;
        count_r      <= count_nxt;
      end

      if (advance && produce) begin
        out_vld_r <= 1'b1;
      end else if (!out_stall) begin
        out_vld_r <= 1'b0;
      end
    end

    // payload, no reset
    if (in_valid && !in_stall) begin
      byte_r <= in_data_byte;
      last_r <= in_message_end;
    end
    if (advance && produce) begin
      o_zone_r  <= pend_zone_r;
      o_start_r <= pend_start_r;
      o_end_r   <= acc_r;
      o_idx_r   <= o_idx_nxt;
      o_drop_r  <= o_drop_nxt;
    end
  end

endmodule

// ----- src/skn_checker.sv -----
// skn_checker: port-level assertions for schedule_key_number_parser_unit
// depends on skn_pkg; attached to the top level by the bind below
module skn_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic [31:0] out_end_value,
  input logic [5:0]  out_entry_index,
  input logic        out_dropped
);

  // a stalled result stays and holds its value
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_end_value))
    else $error("stalled result changed or vanished");

  // a new result comes from an item that was accepted into the input register
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_valid && !in_stall, 2))
    else $error("result without an item accepted two cycles before");

  // dropped entries report the last table slot
  a_drop_idx: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_dropped |-> out_entry_index == 6'(skn_pkg::TABLE_CAPACITY - 1))
    else $error("dropped entry not at the last slot");

  // reset empties the result register
  a_reset: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind schedule_key_number_parser_unit skn_checker u_skn_checker (.*);

// ----- dv/tb_top.sv -----
`timescale 1ns / 100ps
// tb_top: self-checking bench for schedule_key_number_parser_unit, predicts each schedule entry
// from the accepted bytes and checks it field by field; depends on skn_pkg and the parser top
module tb_top;

  localparam int ITEM_TARGET  = 1950;
  localparam int ENTRY_TARGET = 60;
  localparam int DRAIN_CYCLES = 20;
  localparam int CYCLE_LIMIT  = 400000;

  typedef enum logic [1:0] {SEEK_LETTER, IN_KEY, SEEK_DIGIT, IN_NUMBER} parse_phase_t;

  typedef struct packed {
    logic [31:0] zone;
    logic [31:0] start_val;
    logic [31:0] end_val;
    logic [5:0]  slot;
    logic        dropped;
  } sched_entry_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [7:0]  in_data_byte = 8'h00;
  logic        in_message_end = 1'b0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [31:0] out_zone_number;
  logic [31:0] out_start_value;
  logic [31:0] out_end_value;
  logic [5:0]  out_entry_index;
  logic        out_dropped;

  int unsigned send_idle_pct = 38;
  int unsigned recv_idle_pct = 79;
  int unsigned items_sent = 0;
  int unsigned cycle_count = 0;
  logic [7:0]  msg[$];

  schedule_key_number_parser_unit dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_data_byte    (in_data_byte),
    .in_message_end  (in_message_end),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_zone_number (out_zone_number),
    .out_start_value (out_start_value),
    .out_end_value   (out_end_value),
    .out_entry_index (out_entry_index),
    .out_dropped     (out_dropped)
  );

  // character classes
  function automatic bit is_alpha(logic [7:0] b);
    return (b >= skn_pkg::CHR_UPPER_A && b <= skn_pkg::CHR_UPPER_Z)
        || (b >= skn_pkg::CHR_LOWER_A && b <= skn_pkg::CHR_LOWER_Z);
  endfunction

  function automatic bit is_num(logic [7:0] b);
    return b >= skn_pkg::CHR_ZERO && b <= skn_pkg::CHR_NINE;
  endfunction

  // parser predictor and queue of entries still due from the block
  class entry_scoreboard;
    parse_phase_t  phase;
    logic [2:0]    key_hits;
    int unsigned   key_count;
    skn_pkg::key_t found_key;
    logic [31:0]   number_acc;
    logic [31:0]   zone_now;
    logic [31:0]   zone_pending;
    logic [31:0]   start_pending;
    int unsigned   stored_entries;
    string         key_words[skn_pkg::NUM_KEYS];
    sched_entry_t  due_entries[$];
    int unsigned   entries_made;
    int unsigned   fail_count;

    function new();
      key_words[skn_pkg::KEY_ZONE]  = "zoneNumber";
      key_words[skn_pkg::KEY_START] = "startTime";
      key_words[skn_pkg::KEY_END]   = "endTime";
      restart_token();
      zone_now       = '0;
      zone_pending   = '0;
      start_pending  = '0;
      stored_entries = 0;
      entries_made   = 0;
      fail_count     = 0;
    endfunction

    function void restart_token();
      phase      = SEEK_LETTER;
      key_hits   = '1;
      key_count  = 0;
      found_key  = skn_pkg::KEY_ZONE;
      number_acc = '0;
    endfunction

    // narrow the candidate keys by one more letter; overlong runs match nothing
    function void add_key_letter(logic [7:0] b);
      for (int k = 0; k < skn_pkg::NUM_KEYS; k++) begin
        if (key_hits[k] && (key_count >= key_words[k].len() || key_words[k][key_count] != b))
          key_hits[k] = 1'b0;
      end
      if (key_count <= skn_pkg::MAX_KEY_LETTERS) key_count++;
      if (key_count > skn_pkg::MAX_KEY_LETTERS) key_hits = '0;
    endfunction

    // advance the parse by one accepted byte, queue an entry on an end time
    function void parse_byte(logic [7:0] b, logic last);
      logic [35:0]  wide;
      sched_entry_t e;
      bit           full;
      case (phase)
        SEEK_LETTER: begin
          if (is_alpha(b)) begin
            key_hits  = '1;
            key_count = 0;
            add_key_letter(b);
            phase = IN_KEY;
          end
        end
        IN_KEY: begin
          if (is_alpha(b)) begin
            add_key_letter(b);
          end else begin
            phase = SEEK_LETTER;
            for (int k = 0; k < skn_pkg::NUM_KEYS; k++) begin
              if (key_hits[k] && key_count == key_words[k].len()) begin
                found_key  = skn_pkg::key_t'(k);
                number_acc = '0;
                phase      = SEEK_DIGIT;
              end
            end
          end
        end
        SEEK_DIGIT: begin
          if (is_num(b)) begin
            number_acc = 32'(b - skn_pkg::CHR_ZERO);
            phase = IN_NUMBER;
          end
        end
        default: begin
          if (is_num(b)) begin
            // decimal accumulate, saturating at all ones
            wide = {4'b0, number_acc} * 36'd10 + 36'(b - skn_pkg::CHR_ZERO);
            number_acc = (wide > 36'hFFFF_FFFF) ? '1 : wide[31:0];
          end else begin
            case (found_key)
              skn_pkg::KEY_ZONE: zone_now = number_acc;
              skn_pkg::KEY_START: begin
                zone_pending  = zone_now;
                start_pending = number_acc;
              end
              skn_pkg::KEY_END: begin
                full        = stored_entries >= skn_pkg::TABLE_CAPACITY;
                e.zone      = zone_pending;
                e.start_val = start_pending;
                e.end_val   = number_acc;
                e.slot      = 6'(full ? skn_pkg::TABLE_CAPACITY - 1 : stored_entries);
                e.dropped   = full;
                due_entries.push_back(e);
                entries_made++;
                if (!full) stored_entries++;
                zone_pending  = '0;
                start_pending = '0;
              end
              default: ;
            endcase
            phase = SEEK_LETTER;
          end
        end
      endcase
      // message end drops the partial token and the current zone
      if (last) begin
        restart_token();
        zone_now = '0;
      end
    endfunction

    function void report_field(string what, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
        fail_count++;
        $display("%0t: %s mismatch, expected %0d actual %0d", $time, what, want, got);
      end
    endfunction

    function void check_entry(sched_entry_t got);
      sched_entry_t want;
      if (due_entries.size() == 0) begin
        fail_count++;
        $display("%0t: unexpected entry, expected none, actual end_value %0d slot %0d",
                 $time, got.end_val, got.slot);
        return;
      end
      want = due_entries.pop_front();
      report_field("zone_number", want.zone, got.zone);
      report_field("start_value", want.start_val, got.start_val);
      report_field("end_value", want.end_val, got.end_val);
      report_field("entry_index", 32'(want.slot), 32'(got.slot));
      report_field("dropped", 32'(want.dropped), 32'(got.dropped));
    endfunction
  endclass

  entry_scoreboard book = new();

  // message building
  function automatic void push_text(string s);
    for (int i = 0; i < s.len(); i++) msg.push_back(s[i]);
  endfunction

  function automatic void push_number();
    int unsigned pick;
    int unsigned n;
    pick = $urandom_range(99);
    if (pick < 4) begin
      push_text("4294967295");
    end else if (pick < 8) begin
      push_text("4294967296");
    end else begin
      n = (pick < 70) ? $urandom_range(3, 1) : (pick < 88) ? $urandom_range(10, 4)
                                                             : $urandom_range(14, 11);
      repeat (n) msg.push_back(skn_pkg::CHR_ZERO + 8'($urandom_range(9)));
    end
  endfunction

  function automatic logic [7:0] any_letter();
    return 8'($urandom_range(25))
         + (($urandom_range(1) != 0) ? skn_pkg::CHR_LOWER_A : skn_pkg::CHR_UPPER_A);
  endfunction

  // key terminator: separator, digit, or any other non-letter
  function automatic void push_non_letter();
    string       seps;
    logic [7:0]  b;
    int unsigned pick;
    seps = ":=,; \"\t{}";
    pick = $urandom_range(99);
    if (pick < 50) begin
      b = seps[$urandom_range(seps.len() - 1)];
    end else if (pick < 62) begin
      b = skn_pkg::CHR_ZERO + 8'($urandom_range(9));
    end else begin
      do b = 8'($urandom_range(255)); while (is_alpha(b));
    end
    msg.push_back(b);
  endfunction

  // number terminator: separator, letter, or any other non-digit
  function automatic void push_non_digit();
    string       seps;
    logic [7:0]  b;
    int unsigned pick;
    seps = ":=,; \"\t{}";
    pick = $urandom_range(99);
    if (pick < 50) begin
      b = seps[$urandom_range(seps.len() - 1)];
    end else if (pick < 65) begin
      b = any_letter();
    end else begin
      do b = 8'($urandom_range(255)); while (is_num(b));
    end
    msg.push_back(b);
  endfunction

  function automatic void push_key_field(string key);
    push_text(key);
    push_non_letter();
    if ($urandom_range(3) == 0) push_non_digit();
    push_number();
    push_non_digit();
  endfunction

  // mostly well-formed key/number fields, with near misses, noise and cut-off messages
  function automatic void make_message();
    string       near_miss[8];
    int unsigned pick;
    int unsigned cut;
    near_miss = '{"endTim", "endTimee", "EndTime", "zoneNumbers", "startTim", "zonenumber",
                  "startTimeX", "endTimeendTime"};
    msg.delete();
    repeat ($urandom_range(6, 1)) begin
      pick = $urandom_range(99);
      if (pick < 15) begin
        push_key_field("zoneNumber");
      end else if (pick < 38) begin
        push_key_field("startTime");
      end else if (pick < 78) begin
        push_key_field("endTime");
      end else if (pick < 86) begin
        push_key_field(near_miss[$urandom_range(7)]);
      end else if (pick < 92) begin
        repeat ($urandom_range(14, 1)) msg.push_back(any_letter());
        push_non_letter();
      end else begin
        repeat ($urandom_range(4, 1)) msg.push_back(8'($urandom_range(255)));
      end
    end
    if ($urandom_range(9) == 0) begin
      cut = $urandom_range(msg.size() - 1);
      repeat (cut) void'(msg.pop_back());
    end
  endfunction

  // hand one byte to the parser, with random idle cycles ahead of it
  task automatic send_byte(input logic [7:0] b, input logic last);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid       <= 1'b1;
    in_data_byte   <= b;
    in_message_end <= last;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    book.parse_byte(b, last);
    items_sent++;
  endtask

  task automatic send_message(input bit close);
    for (int i = 0; i < msg.size(); i++) send_byte(msg[i], close && i == msg.size() - 1);
  endtask

  // clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) cycle_count <= cycle_count + 1;

  // result side: check accepted entries, stall at random
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall)
      book.check_entry('{zone: out_zone_number, start_val: out_start_value,
                         end_val: out_end_value, slot: out_entry_index,
                         dropped: out_dropped});
    out_stall <= ($urandom_range(99) < recv_idle_pct);
  end

  // stimulus and end of run
  initial begin
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // control and non-ascii noise, key ended by a non-ascii byte, saturating number ended by a
    // letter that must not open a key, then a lone letter closing the message
    msg.delete();
    msg.push_back(8'h00);
    msg.push_back(8'hFF);
    msg.push_back(8'h7F);
    push_text("endTime");
    msg.push_back(8'hFF);
    push_text("4294967296");
    push_text("ez");
    send_message(1'b1);

    // random messages over three idle profiles
    while (items_sent < ITEM_TARGET || book.entries_made < ENTRY_TARGET) begin
      if (items_sent >= 2 * ITEM_TARGET / 3) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end else if (items_sent >= ITEM_TARGET / 3) begin
        send_idle_pct = 79;
        recv_idle_pct = 38;
      end
      make_message();
      send_message($urandom_range(99) < 85);
    end
    in_valid <= 1'b0;

    while (book.due_entries.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (book.fail_count == 0)
      $display("Test completed successfully");
    else
      $display("Test completed with failures");
    $finish;
  end

  // run-away guard
  initial begin
    while (cycle_count < CYCLE_LIMIT) @(posedge clk);
    $display("Test completed with failures");
    $finish;
  end

endmodule
